FILE: src/lesf_pkg.sv
// Shared widths, register indexes and the result type for the largest empty square finder.
// No dependencies.
package lesf_pkg;

    localparam int SIDE_W      = 11;
    localparam int LEFT_W      = 10;
    localparam int TOP_W       = 10;
    localparam int CFG_DATA_W  = 11;
    localparam int CFG_IDX_W   = 1;

    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    localparam int RES_Q_DEPTH = 2;
    localparam int RES_Q_PTR_W = 1;
    localparam int RES_Q_CNT_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'd1;

    typedef struct packed {
        logic [SIDE_W-1:0] side;
        logic [LEFT_W-1:0] left;
        logic [TOP_W-1:0]  top;
    } t_result;

endpackage

FILE: src/lesf_cell_if.sv
// Input channel: one grid cell per item.
// No dependencies.
interface lesf_cell_if;
    logic valid;
    logic ready;
    logic cell_blocked;

    modport source (output valid, output cell_blocked, input ready);
    modport sink   (input valid, input cell_blocked, output ready);
endinterface

FILE: src/lesf_square_if.sv
// Output channel: one square result per item.
// Depends on lesf_pkg for the field widths.
interface lesf_square_if;
    logic                        valid;
    logic                        ready;
    logic [lesf_pkg::SIDE_W-1:0] square_side;
    logic [lesf_pkg::LEFT_W-1:0] square_left;
    logic [lesf_pkg::TOP_W-1:0]  square_top;

    modport source (output valid, output square_side, output square_left,
                    output square_top, input ready);
    modport sink   (input valid, input square_side, input square_left,
                    input square_top, output ready);
endinterface

FILE: src/lesf_res_q.sv
// Two-entry result queue between the compute stage and the output channel.
// Depends on lesf_pkg.
module lesf_res_q (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  lesf_pkg::t_result                   i_item,
    input  logic                                i_pop,
    output logic                                o_valid,
    output lesf_pkg::t_result                   o_item,
    output logic [lesf_pkg::RES_Q_CNT_W-1:0]    o_count
);

    lesf_pkg::t_result                       r_mem [lesf_pkg::RES_Q_DEPTH];
    logic [lesf_pkg::RES_Q_PTR_W-1:0]        r_wr_ptr;
    logic [lesf_pkg::RES_Q_PTR_W-1:0]        r_rd_ptr;
    logic [lesf_pkg::RES_Q_CNT_W-1:0]        r_count;
    logic [lesf_pkg::RES_Q_CNT_W-1:0]        n_count;

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

FILE: src/largest_empty_square_finder_unit.sv
// Largest empty square finder, top level: counters, line store, compute stage, assertions.
// Depends on lesf_pkg, lesf_cell_if, lesf_square_if and lesf_res_q.
//
// Usage: set grid_rows (index 0) and grid_cols (index 1) through the write port while
// the block is idle; each write starts a fresh grid. Then stream the grid over i_cell,
// row by row, left to right, one cell per item. After the last cell one item leaves on
// o_square: side of the largest all-empty square and its top-left column and row.
// Throughput: one cell per cycle while i_cell.ready is high, set by the single read and
// single write per cycle of the line store (one entry per column).
// Result path: the last cell is held in the cell register, then its result is pushed into
// the result queue, which drives o_square.valid.
// Reset: grid is 1 x 1, position and best square cleared; no clearing pass is needed,
// the line store is only read at rows that have already written it.
// Stall: results go into a two-entry queue; i_cell.ready drops only when a further
// result could not be held, so cells keep flowing while a result waits.
module largest_empty_square_finder_unit #(
    parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [lesf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [lesf_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    lesf_cell_if.sink                           i_cell,
    lesf_square_if.source                       o_square
);

    localparam int CW = $clog2(MAX_COLS);
    localparam int RW = $clog2(MAX_ROWS);
    localparam int SW = lesf_pkg::SIDE_W;
    localparam int AW = (CW > SW) ? CW : SW;
    localparam int BW = (RW > SW) ? RW : SW;
    localparam int QW = lesf_pkg::RES_Q_CNT_W + 1;

    // grid shape and position of the next cell
    logic [CW-1:0] r_last_col;
    logic [RW-1:0] r_last_row;
    logic [CW-1:0] r_col_cnt;
    logic [RW-1:0] r_row_cnt;

    // compute stage inputs
    logic          r_vld;
    logic          r_blk;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic          r_last;
    logic          r_fwd;
    logic [SW-1:0] r_fwd_data;
    logic [SW-1:0] r_rd;

    logic [SW-1:0] r_run_line [MAX_COLS];

    // running state
    logic [SW-1:0]               r_left_run;
    logic [SW-1:0]               r_diag_run;
    logic [SW-1:0]               r_best_side;
    logic [lesf_pkg::LEFT_W-1:0] r_best_left;
    logic [lesf_pkg::TOP_W-1:0]  r_best_top;

    logic          w_accept;
    logic          w_eol;
    logic          w_next_last;
    logic [CW-1:0] n_last_col;
    logic [RW-1:0] n_last_row;

    logic [SW-1:0] w_up;
    logic [SW-1:0] w_left;
    logic [SW-1:0] w_diag;
    logic [SW-1:0] w_min;
    logic [SW-1:0] w_v;
    logic          w_better;
    lesf_pkg::t_result n_best;

    logic                              w_q_valid;
    logic                              w_q_pop;
    lesf_pkg::t_result                 w_q_item;
    logic [lesf_pkg::RES_Q_CNT_W-1:0]  w_q_cnt;

    // input side
    assign w_eol       = (r_col_cnt == r_last_col);
    assign w_next_last = w_eol && (r_row_cnt == r_last_row);
    assign w_q_pop     = w_q_valid && o_square.ready;

    assign i_cell.ready = (QW'(w_q_cnt) + QW'(r_vld && r_last) + QW'(w_next_last))
                          <= (QW'(lesf_pkg::RES_Q_DEPTH) + QW'(w_q_pop));
    assign w_accept     = i_cell.valid && i_cell.ready;

    // clamp of the written sizes, stored as last index
    always_comb begin
        if (i_cfg_data == '0) begin
            n_last_row = '0;
            n_last_col = '0;
        end else begin
            if (32'(i_cfg_data) > 32'(MAX_ROWS)) begin
                n_last_row = RW'(MAX_ROWS - 1);
            end else begin
                n_last_row = RW'(i_cfg_data - 1'b1);
            end
            if (32'(i_cfg_data) > 32'(MAX_COLS)) begin
                n_last_col = CW'(MAX_COLS - 1);
            end else begin
                n_last_col = CW'(i_cfg_data - 1'b1);
            end
        end
    end

    // compute stage
    always_comb begin
        w_up   = (r_row == '0) ? '0 : (r_fwd ? r_fwd_data : r_rd);
        w_left = (r_col == '0) ? '0 : r_left_run;
        w_diag = (r_col == '0 || r_row == '0) ? '0 : r_diag_run;
        w_min  = (w_up < w_left) ? w_up : w_left;
        if (w_diag < w_min) begin
            w_min = w_diag;
        end
        w_v      = r_blk ? '0 : (w_min + 1'b1);
        w_better = (w_v > r_best_side);
        if (w_better) begin
            n_best.side = w_v;
            n_best.left = lesf_pkg::LEFT_W'(AW'(r_col) + AW'(1) - AW'(w_v));
            n_best.top  = lesf_pkg::TOP_W'(BW'(r_row) + BW'(1) - BW'(w_v));
        end else begin
            n_best.side = r_best_side;
            n_best.left = r_best_left;
            n_best.top  = r_best_top;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_col  <= '0;
            r_last_row  <= '0;
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_vld       <= 1'b0;
            r_left_run  <= '0;
            r_diag_run  <= '0;
            r_best_side <= '0;
            r_best_left <= '0;
            r_best_top  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lesf_pkg::REG_GRID_ROWS: r_last_row <= n_last_row;
                lesf_pkg::REG_GRID_COLS: r_last_col <= n_last_col;
            endcase
            r_col_cnt   <= '0;
            r_row_cnt   <= '0;
            r_vld       <= 1'b0;
            r_left_run  <= '0;
            r_diag_run  <= '0;
            r_best_side <= '0;
            r_best_left <= '0;
            r_best_top  <= '0;
        end else begin
            r_vld <= w_accept;
            if (w_accept) begin
                if (w_next_last) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= '0;
                end else if (w_eol) begin
                    r_col_cnt <= '0;
                    r_row_cnt <= r_row_cnt + 1'b1;
                end else begin
                    r_col_cnt <= r_col_cnt + 1'b1;
                end
            end
            if (r_vld) begin
                r_left_run <= w_v;
                r_diag_run <= w_up;
                if (r_last) begin
                    r_best_side <= '0;
                    r_best_left <= '0;
                    r_best_top  <= '0;
                end else begin
                    r_best_side <= n_best.side;
                    r_best_left <= n_best.left;
                    r_best_top  <= n_best.top;
                end
            end
        end
    end

    // cell register, line store read and same-column bypass
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_blk      <= i_cell.cell_blocked;
            r_col      <= r_col_cnt;
            r_row      <= r_row_cnt;
            r_last     <= w_next_last;
            r_rd       <= r_run_line[r_col_cnt];
            r_fwd      <= r_vld && (r_col == r_col_cnt);
            r_fwd_data <= w_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_vld) begin
            r_run_line[r_col] <= w_v;
        end
    end

    lesf_res_q u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_vld && r_last),
        .i_item  (n_best),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_count (w_q_cnt)
    );

    assign o_square.valid       = w_q_valid;
    assign o_square.square_side = w_q_item.side;
    assign o_square.square_left = w_q_item.left;
    assign o_square.square_top  = w_q_item.top;

    a_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(w_q_cnt) <= lesf_pkg::RES_Q_DEPTH)
        else $error("result queue overflow");

    a_result_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_square.valid) |-> $past(r_vld && r_last))
        else $error("result without a last cell");

    a_wrap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_next_last && !i_cfg_we) |=> (r_col_cnt == '0 && r_row_cnt == '0))
        else $error("position not cleared after last cell");

    a_bypass_single_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld && r_fwd) |-> (r_last_col == '0))
        else $error("bypass taken on a multi-column grid");

endmodule

FILE: tb/sv/testbench.sv
// Testbench for largest_empty_square_finder_unit: streams binary grids cell by cell and
// checks each item against a plan value or a maximal-square predictor kept in step.
// Depends on lesf_pkg, lesf_cell_if, lesf_square_if and the block itself.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int RESULT_LATENCY = 2;
    localparam int RANDOM_CELLS   = 650;
    localparam int MIN_GRIDS      = 12;
    localparam int PLAN_LEN       = 31;

    typedef enum logic {ROW_CFG, ROW_CELL} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [lesf_pkg::CFG_IDX_W-1:0]     idx;
        logic [lesf_pkg::CFG_DATA_W-1:0]    value;
        logic                               blocked;
        logic                               typed;
        lesf_pkg::t_result                  want;
    } t_plan_row;

    localparam lesf_pkg::t_result NO_SQUARE = '0;

    logic                               i_clk;
    logic                               i_rst_n;
    logic                               i_cfg_we;
    logic [lesf_pkg::CFG_IDX_W-1:0]     i_cfg_idx;
    logic [lesf_pkg::CFG_DATA_W-1:0]    i_cfg_data;

    lesf_cell_if   cell_ch ();
    lesf_square_if square_ch ();

    largest_empty_square_finder_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_cell     (cell_ch),
        .o_square   (square_ch)
    );

    // predictor state
    logic [lesf_pkg::SIDE_W-1:0] run_row [lesf_pkg::DEF_MAX_COLS];
    int unsigned       grid_rows_reg;
    int unsigned       grid_cols_reg;
    int unsigned       col_pos;
    int unsigned       row_pos;
    int unsigned       left_len;
    int unsigned       diag_len;
    int unsigned       best_len;
    int unsigned       best_col;
    int unsigned       best_row;

    lesf_pkg::t_result pending_squares [$];
    lesf_pkg::t_result predicted;
    lesf_pkg::t_result observed;
    lesf_pkg::t_result oldest;
    t_plan_row         plan [PLAN_LEN];

    bit                typed_on;
    lesf_pkg::t_result typed_square;
    bit          calm;
    int          idle_pct;
    int          stall_left;
    int          cycle_cnt;
    int          mismatch_cnt;
    int          cells_sent;
    int          squares_seen;
    int          random_base;
    int          grids_base;
    int          rows_val;
    int          cols_val;
    int          fill_pct;
    int          spin;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned fit_size(int unsigned v, int unsigned hi);
        if (v == 0)
            return 1;
        return (v > hi) ? hi : v;
    endfunction

    function automatic void clear_grid();
        for (int i = 0; i < lesf_pkg::DEF_MAX_COLS; i++)
            run_row[i] = '0;
        col_pos  = 0;
        row_pos  = 0;
        left_len = 0;
        diag_len = 0;
        best_len = 0;
        best_col = 0;
        best_row = 0;
    endfunction

    function automatic void apply_reg(logic [lesf_pkg::CFG_IDX_W-1:0] idx,
                                      logic [lesf_pkg::CFG_DATA_W-1:0] value);
        if (idx == lesf_pkg::REG_GRID_ROWS) begin
            grid_rows_reg = value;
        end else if (idx == lesf_pkg::REG_GRID_COLS) begin
            grid_cols_reg = value;
        end
        clear_grid();
    endfunction

    function automatic bit track_square(logic blocked, output lesf_pkg::t_result sq);
        int unsigned rows, cols, c, up, lft, dg, m, v;
        rows = fit_size(grid_rows_reg, lesf_pkg::DEF_MAX_ROWS);
        cols = fit_size(grid_cols_reg, lesf_pkg::DEF_MAX_COLS);
        c    = (col_pos >= lesf_pkg::DEF_MAX_COLS) ? lesf_pkg::DEF_MAX_COLS - 1 : col_pos;
        up   = (row_pos == 0) ? 0 : run_row[c];
        lft  = (c == 0) ? 0 : left_len;
        dg   = (c == 0 || row_pos == 0) ? 0 : diag_len;
        sq   = NO_SQUARE;
        if (blocked) begin
            v = 0;
        end else begin
            m = (up < lft) ? up : lft;
            if (dg < m)
                m = dg;
            v = (m + 1) & 'h7FF;
        end
        if (v > best_len) begin
            best_len = v;
            best_col = c + 1 - v;
            best_row = row_pos + 1 - v;
        end
        diag_len   = up;
        left_len   = v;
        run_row[c] = v[lesf_pkg::SIDE_W-1:0];
        if (c + 1 < cols) begin
            col_pos = c + 1;
            return 1'b0;
        end
        col_pos  = 0;
        left_len = 0;
        diag_len = 0;
        if (row_pos + 1 < rows) begin
            row_pos = row_pos + 1;
            return 1'b0;
        end
        sq.side = best_len[lesf_pkg::SIDE_W-1:0];
        sq.left = best_col[lesf_pkg::LEFT_W-1:0];
        sq.top  = best_row[lesf_pkg::TOP_W-1:0];
        clear_grid();
        return 1'b1;
    endfunction

    function automatic void report(string msg);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t: %s", $realtime, msg);
    endfunction

    // predictor update and result check, all at the rising edge
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else if (!i_rst_n) begin
            grid_rows_reg = 1;
            grid_cols_reg = 1;
            clear_grid();
        end else begin
            if (i_cfg_we)
                apply_reg(i_cfg_idx, i_cfg_data);
            if (cell_ch.valid && cell_ch.ready) begin
                if (track_square(cell_ch.cell_blocked, predicted) || typed_on)
                    pending_squares.push_back(typed_on ? typed_square : predicted);
            end
            if (square_ch.valid && square_ch.ready) begin
                squares_seen++;
                observed.side = square_ch.square_side;
                observed.left = square_ch.square_left;
                observed.top  = square_ch.square_top;
                if (pending_squares.size() == 0) begin
                    report($sformatf("unexpected item: side %0d left %0d top %0d",
                                     observed.side, observed.left, observed.top));
                end else begin
                    oldest = pending_squares.pop_front();
                    if (observed.side != oldest.side || observed.left != oldest.left ||
                        observed.top != oldest.top)
                        report($sformatf({"mismatch: expected side %0d left %0d top %0d,",
                                          " got side %0d left %0d top %0d"},
                                         oldest.side, oldest.left, oldest.top,
                                         observed.side, observed.left, observed.top));
                end
            end
        end
    end

    initial begin
        square_ch.ready = 1'b0;
        stall_left      = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                square_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                square_ch.ready <= 1'b1;
                if (!calm && idle_pct != 0 && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 10);
            end
        end
    end

    task automatic push_cell(logic blocked, bit typed, lesf_pkg::t_result want);
        if (!calm && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            cell_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10) - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        cell_ch.valid        <= 1'b1;
        cell_ch.cell_blocked <= blocked;
        typed_on     = typed;
        typed_square = want;
        do
            @(posedge i_clk);
        while (!cell_ch.ready);
        cells_sent++;
    endtask

    task automatic send_grid(int rows, int cols, int pct);
        for (int n = 0; n < rows * cols; n++)
            push_cell($urandom_range(0, 99) < pct, 1'b0, NO_SQUARE);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        cell_ch.valid <= 1'b0;
        while (pending_squares.size() != 0)
            @(posedge i_clk);
        repeat (RESULT_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_reg(logic [lesf_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[lesf_pkg::CFG_DATA_W-1:0];
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 19);
        if (r < 2)
            return 0;
        if (r < 12)
            return $urandom_range(1, 4);
        if (r < 19)
            return $urandom_range(5, 12);
        return $urandom_range(13, 32);
    endfunction

    initial begin
        i_rst_n              = 1'b0;
        i_cfg_we             = 1'b0;
        i_cfg_idx            = lesf_pkg::REG_GRID_ROWS;
        i_cfg_data           = '0;
        cell_ch.valid        = 1'b0;
        cell_ch.cell_blocked = 1'b0;
        typed_on             = 1'b0;
        typed_square         = NO_SQUARE;
        calm                 = 1'b0;
        idle_pct             = 20;
        cycle_cnt            = 0;
        mismatch_cnt         = 0;
        cells_sent           = 0;
        squares_seen         = 0;

        plan = '{
            // 1 x 1 grid after reset
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b1, {11'd1, 10'd0, 10'd0}},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b1, {11'd0, 10'd0, 10'd0}},
            '{ROW_CFG,  lesf_pkg::REG_GRID_ROWS, 11'd2, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CFG,  lesf_pkg::REG_GRID_COLS, 11'd2, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b1, {11'd2, 10'd0, 10'd0}},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            // zero rows count as one
            '{ROW_CFG,  lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CFG,  lesf_pkg::REG_GRID_COLS, 11'd3, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            // tie between two squares of side 2: topmost wins
            '{ROW_CFG,  lesf_pkg::REG_GRID_ROWS, 11'd3, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CFG,  lesf_pkg::REG_GRID_COLS, 11'd2, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b0, 1'b1, {11'd2, 10'd0, 10'd0}},
            // no empty cell
            '{ROW_CFG,  lesf_pkg::REG_GRID_ROWS, 11'd2, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CFG,  lesf_pkg::REG_GRID_COLS, 11'd2, 1'b0, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b0, NO_SQUARE},
            '{ROW_CELL, lesf_pkg::REG_GRID_ROWS, 11'd0, 1'b1, 1'b1, {11'd0, 10'd0, 10'd0}}
        };

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                wait_drained();
                set_reg(plan[i].idx, plan[i].value);
            end else begin
                push_cell(plan[i].blocked, plan[i].typed, plan[i].want);
            end
        end

        random_base = cells_sent;
        grids_base  = squares_seen;
        while ((cells_sent - random_base) < RANDOM_CELLS ||
               (squares_seen - grids_base) < MIN_GRIDS) begin
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 10;
                default: idle_pct = 30;
            endcase
            calm = (cells_sent - random_base) >= (RANDOM_CELLS * 85) / 100;
            wait_drained();
            rows_val = pick_dim();
            cols_val = pick_dim();
            if ($urandom_range(0, 1)) begin
                set_reg(lesf_pkg::REG_GRID_ROWS, rows_val);
                set_reg(lesf_pkg::REG_GRID_COLS, cols_val);
            end else begin
                set_reg(lesf_pkg::REG_GRID_COLS, cols_val);
                set_reg(lesf_pkg::REG_GRID_ROWS, rows_val);
            end
            case ($urandom_range(0, 5))
                0: fill_pct = 0;
                1: fill_pct = 5;
                2: fill_pct = 20;
                3: fill_pct = 50;
                4: fill_pct = 95;
                default: fill_pct = 100;
            endcase
            repeat ($urandom_range(1, 3))
                send_grid(fit_size(rows_val, lesf_pkg::DEF_MAX_ROWS),
                          fit_size(cols_val, lesf_pkg::DEF_MAX_COLS), fill_pct);
        end

        // widest row through an oversized column value, zero rows count as one
        calm = 1'b1;
        wait_drained();
        set_reg(lesf_pkg::REG_GRID_COLS, 2047);
        set_reg(lesf_pkg::REG_GRID_ROWS, 0);
        send_grid(1, lesf_pkg::DEF_MAX_COLS, 10);

        @(negedge i_clk);
        cell_ch.valid <= 1'b0;
        spin = 0;
        while (pending_squares.size() != 0 && spin < 5000) begin
            @(posedge i_clk);
            spin++;
        end
        repeat (RESULT_LATENCY + 8) @(posedge i_clk);
        if (pending_squares.size() != 0)
            report($sformatf("%0d expected items never arrived", pending_squares.size()));

        if (mismatch_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
src/lesf_pkg.sv
src/lesf_cell_if.sv
src/lesf_square_if.sv
src/lesf_res_q.sv
src/largest_empty_square_finder_unit.sv
tb/sv/testbench.sv
